// File: rtl/pff_pkg.sv
`default_nettype none

package pff_pkg;

    // Field widths
    localparam int POS_W     = 24;   // positions, 8 fractional bits
    localparam int DIR_W     = 16;   // forward components, 14 fractional bits
    localparam int DENS_W    = 24;   // fog density, 24 fractional bits
    localparam int MIX_W     = 17;   // fog mix, 16 fractional bits

    // Default grid of the fractional exp table
    localparam int PFF_FRAC_TABLE_BITS = 8;

    // Register reset values
    localparam logic [POS_W-1:0]  CAMERA_RESET    = '0;
    localparam logic [DIR_W-1:0]  FORWARD_X_RESET = 16'd16384;
    localparam logic [DIR_W-1:0]  FORWARD_YZ_RESET = '0;
    localparam logic [DENS_W-1:0] DENSITY_RESET   = 24'd33554;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Floor division by the term index of the series; each arm divides by a literal
    function automatic logic [63:0] div_term(input logic [63:0] a, input int unsigned n);
        logic [63:0] q;
        case (n)
            1:       q = a;
            2:       q = a / 2;
            3:       q = a / 3;
            4:       q = a / 4;
            5:       q = a / 5;
            6:       q = a / 6;
            7:       q = a / 7;
            8:       q = a / 8;
            9:       q = a / 9;
            10:      q = a / 10;
            11:      q = a / 11;
            12:      q = a / 12;
            13:      q = a / 13;
            14:      q = a / 14;
            15:      q = a / 15;
            16:      q = a / 16;
            17:      q = a / 17;
            18:      q = a / 18;
            19:      q = a / 19;
            20:      q = a / 20;
            default: q = a;
        endcase
        return q;
    endfunction

    // exp(-f), f in [0,1] with 30 fractional bits, 21-term series, terms truncated
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        longint      sum;
        logic [63:0] term;
        sum  = longint'(Q30_ONE);
        term = Q30_ONE;
        for (int unsigned n = 1; n <= 20; n++)
        begin
            term = div_term((term * f) >> 30, n);
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return 64'(sum);
    endfunction

    // Round 30 fractional bits to 16, half up
    function automatic logic [MIX_W-1:0] q30_to_q16(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << 13)) >> 14;
        return r[MIX_W-1:0];
    endfunction

    // exp(-idx) for idx = 0..15, powers of exp(-1) rounded at 30 bits
    function automatic logic [MIX_W-1:0] int_entry(input int unsigned idx);
        logic [63:0] e1;
        logic [63:0] p;
        e1 = exp_neg_q30(Q30_ONE);
        p  = Q30_ONE;
        for (int unsigned i = 0; i < 16; i++)
        begin
            if (i < idx)
                p = (p * e1 + (Q30_ONE >> 1)) >> 30;
        end
        return q30_to_q16(p);
    endfunction

    // exp(-idx / 2^bits)
    function automatic logic [MIX_W-1:0] frac_entry(input int unsigned idx,
                                                    input int unsigned bits);
        logic [63:0] f;
        f = 64'(idx) << (30 - bits);
        return q30_to_q16(exp_neg_q30(f));
    endfunction

endpackage

`default_nettype wire

// File: rtl/pff_stream_if.sv
`default_nettype none

// Point channel
interface pff_point_if
    import pff_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [POS_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// Fog mix channel
interface pff_fog_if
    import pff_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [MIX_W-1:0] fog_mix;

    modport source (output valid, fog_mix, input ready);
    modport sink   (input valid, fog_mix, output ready);
endinterface

`default_nettype wire

// File: rtl/exp2_planar_fog_factor.sv
`default_nettype none

// Channel   Dir   Payload                           Transfer
// point     in    point_x, point_y, point_z (s24)   valid && ready
// fog       out   fog_mix (u17, 65536 = 1.0)        valid && ready
// apb       in    7 registers at 4*i, 32-bit data   psel && penable && pwrite
//
// Seven register stages; one point per cycle while fog is not stalled.
// The per-stage multipliers (3x 25x16, 24x29, 18x18, 17x17) set the stage split.
// Reset clears the valid bits and loads the register defaults; tables are constants.
// A stall on fog freezes the whole pipe; point.ready follows it combinationally.
module exp2_planar_fog_factor
    import pff_pkg::*;
#(
    parameter int FRAC_TABLE_BITS = PFF_FRAC_TABLE_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pff_point_if.sink        point,
    pff_fog_if.source        fog,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int FRAC_SIZE = 1 << FRAC_TABLE_BITS;

    typedef enum logic [2:0] {
        REG_CAMERA_X  = 3'd0,
        REG_CAMERA_Y  = 3'd1,
        REG_CAMERA_Z  = 3'd2,
        REG_FORWARD_X = 3'd3,
        REG_FORWARD_Y = 3'd4,
        REG_FORWARD_Z = 3'd5,
        REG_DENSITY   = 3'd6
    } reg_index_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]  camera_x_reg, camera_y_reg, camera_z_reg;
    logic signed [DIR_W-1:0]  forward_x_reg, forward_y_reg, forward_z_reg;
    logic        [DENS_W-1:0] density_reg;
    logic                     cfg_write;
    logic        [2:0]        cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg  <= CAMERA_RESET;
            camera_y_reg  <= CAMERA_RESET;
            camera_z_reg  <= CAMERA_RESET;
            forward_x_reg <= FORWARD_X_RESET;
            forward_y_reg <= FORWARD_YZ_RESET;
            forward_z_reg <= FORWARD_YZ_RESET;
            density_reg   <= DENSITY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAMERA_X:  camera_x_reg  <= pwdata[POS_W-1:0];
                REG_CAMERA_Y:  camera_y_reg  <= pwdata[POS_W-1:0];
                REG_CAMERA_Z:  camera_z_reg  <= pwdata[POS_W-1:0];
                REG_FORWARD_X: forward_x_reg <= pwdata[DIR_W-1:0];
                REG_FORWARD_Y: forward_y_reg <= pwdata[DIR_W-1:0];
                REG_FORWARD_Z: forward_z_reg <= pwdata[DIR_W-1:0];
                REG_DENSITY:   density_reg   <= pwdata[DENS_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back, raw bits zero extended
    always_comb
    begin
        case (cfg_index)
            REG_CAMERA_X:  prdata = 32'(unsigned'(camera_x_reg));
            REG_CAMERA_Y:  prdata = 32'(unsigned'(camera_y_reg));
            REG_CAMERA_Z:  prdata = 32'(unsigned'(camera_z_reg));
            REG_FORWARD_X: prdata = 32'(unsigned'(forward_x_reg));
            REG_FORWARD_Y: prdata = 32'(unsigned'(forward_y_reg));
            REG_FORWARD_Z: prdata = 32'(unsigned'(forward_z_reg));
            REG_DENSITY:   prdata = 32'(density_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // exp(-x) tables, integer part and fractional part
    // ------------------------------------------------------------------
    logic [MIX_W-1:0] int_rom  [16];
    logic [MIX_W-1:0] frac_rom [FRAC_SIZE];

    for (genvar gi = 0; gi < 16; gi++)
    begin : g_int_rom
        assign int_rom[gi] = int_entry(gi);
    end

    for (genvar gf = 0; gf < FRAC_SIZE; gf++)
    begin : g_frac_rom
        assign frac_rom[gf] = frac_entry(gf, FRAC_TABLE_BITS);
    end

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe advances unless the output is held
    // ------------------------------------------------------------------
    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    assign advance     = !v7_reg || fog.ready;
    assign point.ready = advance;
    assign fog.valid   = v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= point.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Stage 1: offsets from the camera
    logic signed [POS_W:0] dx_next, dy_next, dz_next;
    logic signed [POS_W:0] dx_reg, dy_reg, dz_reg;

    assign dx_next = (POS_W+1)'(point.point_x) - (POS_W+1)'(camera_x_reg);
    assign dy_next = (POS_W+1)'(point.point_y) - (POS_W+1)'(camera_y_reg);
    assign dz_next = (POS_W+1)'(point.point_z) - (POS_W+1)'(camera_z_reg);

    // Stage 2: per-axis products, 22 fractional bits
    localparam int PROD_W = POS_W + 1 + DIR_W;
    logic signed [PROD_W-1:0] px_next, py_next, pz_next;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;

    assign px_next = dx_reg * forward_x_reg;
    assign py_next = dy_reg * forward_y_reg;
    assign pz_next = dz_reg * forward_z_reg;

    // Stage 3: sum, magnitude, drop 14 fractional bits
    localparam int DOT_W = PROD_W + 2;
    localparam int D8_W  = DOT_W - 14;
    logic signed [DOT_W-1:0] dot;
    logic        [DOT_W-1:0] mag;
    logic        [D8_W-1:0]  d8_next, d8_reg;

    assign dot     = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
    assign mag     = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    assign d8_next = mag[DOT_W-1:14];

    // Stage 4: optical depth, 32 fractional bits
    localparam int T32_W = DENS_W + D8_W;
    logic [T32_W-1:0] t32_next, t32_reg;

    assign t32_next = T32_W'(density_reg) * T32_W'(d8_reg);

    // Stage 5: round to 16 bits, deep-fog test, square
    logic [T32_W-1:0] t32_rnd;
    logic [17:0]      t16;
    logic             deep5_next, deep5_reg;
    logic [35:0]      sq_next, sq_reg;

    assign t32_rnd    = t32_reg + T32_W'(32768);
    assign deep5_next = |t32_rnd[T32_W-1:34];
    assign t16        = t32_rnd[33:16];
    assign sq_next    = 36'(t16) * 36'(t16);

    // Stage 6: x rounded to 16 fractional bits, table lookups
    logic [35:0]                sq_rnd;
    logic [3:0]                 n_idx;
    logic [FRAC_TABLE_BITS-1:0] k_idx;
    logic [MIX_W-1:0]           int_q_reg, frac_q_reg;
    logic                       deep6_reg;

    assign sq_rnd = sq_reg + 36'd32768;
    assign n_idx  = sq_rnd[35:32];
    assign k_idx  = sq_rnd[31:32-FRAC_TABLE_BITS];

    // Stage 7: product, round, clamp
    logic [2*MIX_W-1:0] mix_prod;
    logic [MIX_W-1:0]   mix_rnd;
    logic [MIX_W-1:0]   mix_next, mix_reg;

    assign mix_prod = (2*MIX_W)'(int_q_reg) * (2*MIX_W)'(frac_q_reg) + (2*MIX_W)'(32768);
    assign mix_rnd  = (mix_prod[2*MIX_W-1:32] != '0) ? MIX_W'(65536)
                                                     : mix_prod[32:16];
    assign mix_next = deep6_reg ? '0
                    : ((mix_rnd > MIX_W'(65536)) ? MIX_W'(65536) : mix_rnd);

    assign fog.fog_mix = mix_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
            d8_reg     <= d8_next;
            t32_reg    <= t32_next;
            deep5_reg  <= deep5_next;
            sq_reg     <= sq_next;
            int_q_reg  <= int_rom[n_idx];
            frac_q_reg <= frac_rom[k_idx];
            deep6_reg  <= deep5_reg;
            mix_reg    <= mix_next;
        end
    end

endmodule

`default_nettype wire

// File: dv/pff_tb_pkg.sv
`timescale 1ns / 1ps

package pff_tb_pkg;

    // Register map, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_CAMERA_X    = 3'd0,
        REG_CAMERA_Y    = 3'd1,
        REG_CAMERA_Z    = 3'd2,
        REG_FORWARD_X   = 3'd3,
        REG_FORWARD_Y   = 3'd4,
        REG_FORWARD_Z   = 3'd5,
        REG_FOG_DENSITY = 3'd6,
        REG_SPARE       = 3'd7    // not decoded, writes are dropped
    } pff_reg_e;

endpackage

// File: dv/pff_fog_checker.sv
`timescale 1ns / 1ps

module pff_fog_checker
    import pff_pkg::*;
    import pff_tb_pkg::*;
#(
    parameter int FRAC_BITS = PFF_FRAC_TABLE_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pff_point_if             point,
    pff_fog_if               fog,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               outstanding
);

    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam int          FRAC_ENTRIES = 1 << FRAC_BITS;

    // exp(-n) and exp(-k / 2^FRAC_BITS), 16 fractional bits
    logic [MIX_W-1:0] decay_whole [16];
    logic [MIX_W-1:0] decay_frac  [FRAC_ENTRIES];

    // Shadow of the register file, tracked from the bus
    logic signed [POS_W-1:0] cam_x, cam_y, cam_z;
    logic signed [DIR_W-1:0] fwd_x, fwd_y, fwd_z;
    logic        [DENS_W-1:0] density;

    logic [MIX_W-1:0] expected_mix [$];
    logic [MIX_W-1:0] want_mix;

    // Truncated Taylor series for exp(-f), f in Q30
    function automatic logic [63:0] series_exp_neg(input logic [63:0] f);
        longint      acc;
        logic [63:0] term;
        int          k;
        acc  = longint'(ONE_Q30);
        term = ONE_Q30;
        for (k = 1; k <= 20; k++)
        begin
            term = ((term * f) >> 30) / 64'(k);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    function automatic logic [MIX_W-1:0] round_q16(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd8192) >> 14;
        return r[MIX_W-1:0];
    endfunction

    initial
    begin
        logic [63:0] e1;
        logic [63:0] pw;
        e1 = series_exp_neg(ONE_Q30);
        pw = ONE_Q30;
        for (int i = 0; i < 16; i++)
        begin
            decay_whole[i] = round_q16(pw);
            pw = (pw * e1 + (ONE_Q30 >> 1)) >> 30;
        end
        for (int i = 0; i < FRAC_ENTRIES; i++)
            decay_frac[i] = round_q16(series_exp_neg(64'(i) << (30 - FRAC_BITS)));
    end

    // Fog mix of one point under the current register values
    function automatic logic [MIX_W-1:0] predict_mix(input logic signed [POS_W-1:0] px,
                                                     input logic signed [POS_W-1:0] py,
                                                     input logic signed [POS_W-1:0] pz);
        logic signed [POS_W:0] dx, dy, dz;
        logic signed [47:0]    dot;
        logic        [47:0]    mag;
        logic        [63:0]    t32, t16, x16, whole, prod;
        dx  = px - cam_x;
        dy  = py - cam_y;
        dz  = pz - cam_z;
        dot = dx * fwd_x + dy * fwd_y + dz * fwd_z;
        mag = (dot < 0) ? 48'(-dot) : 48'(dot);
        t32 = 64'(density) * 64'(mag >> 14);
        t16 = (t32 + 64'd32768) >> 16;
        // deep fog
        if (t16 >= (64'd4 << 16))
            return '0;
        x16   = (t16 * t16 + 64'd32768) >> 16;
        whole = x16 >> 16;
        if (whole >= 64'd16)
            return '0;
        // grid remainder below the table step is dropped
        prod = (64'(decay_whole[whole[3:0]]) * 64'(decay_frac[x16[15 -: FRAC_BITS]])
                + 64'd32768) >> 16;
        return (prod > 64'd65536) ? MIX_W'(65536) : prod[MIX_W-1:0];
    endfunction

    // Compare results, queue predictions, follow register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x       <= CAMERA_RESET;
            cam_y       <= CAMERA_RESET;
            cam_z       <= CAMERA_RESET;
            fwd_x       <= FORWARD_X_RESET;
            fwd_y       <= FORWARD_YZ_RESET;
            fwd_z       <= FORWARD_YZ_RESET;
            density     <= DENSITY_RESET;
            expected_mix.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result side first: a point taken at this edge cannot return yet
            if (fog.valid && fog.ready)
            begin
                if (expected_mix.size() == 0)
                begin
                    $error("fog_mix transfer with nothing expected, actual %0d", fog.fog_mix);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want_mix = expected_mix.pop_front();
                    if (fog.fog_mix !== want_mix)
                    begin
                        $error("fog_mix mismatch: expected %0d, actual %0d",
                               want_mix, fog.fog_mix);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (point.valid && point.ready)
                expected_mix.push_back(predict_mix(point.point_x, point.point_y,
                                                   point.point_z));
            outstanding <= expected_mix.size();

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CAMERA_X:    cam_x   <= pwdata[POS_W-1:0];
                    REG_CAMERA_Y:    cam_y   <= pwdata[POS_W-1:0];
                    REG_CAMERA_Z:    cam_z   <= pwdata[POS_W-1:0];
                    REG_FORWARD_X:   fwd_x   <= pwdata[DIR_W-1:0];
                    REG_FORWARD_Y:   fwd_y   <= pwdata[DIR_W-1:0];
                    REG_FORWARD_Z:   fwd_z   <= pwdata[DIR_W-1:0];
                    REG_FOG_DENSITY: density <= pwdata[DENS_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

endmodule

// File: dv/tb_exp2_planar_fog_factor.sv
`timescale 1ns / 1ps

module tb_exp2_planar_fog_factor;
    import pff_pkg::*;
    import pff_tb_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 56;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;
    localparam logic signed [DIR_W-1:0] DIR_ONE = 16'sd16384;

    // With density 2^-8 and unit forward, t in 16 fractional bits equals the raw x: 262144 is t = 4.0
    localparam int BOUNDARY_X [10] = '{0, 1, -1, 65536, -65536, 181019,
                                       262143, -262143, 262144, -262144};

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SOURCE_IDLE,
        PACE_SINK_STALL,
        PACE_BOTH
    } pace_e;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        rcv_ready = 1'b0;
    pace_e       pace = PACE_FULL;
    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;

    // Settings in force, used to aim points near the camera
    logic signed [POS_W-1:0] cam_x, cam_y, cam_z;
    logic signed [DIR_W-1:0] fwd_x, fwd_y, fwd_z;
    logic        [DENS_W-1:0] density;

    pff_point_if point_ch ();
    pff_fog_if   fog_ch ();

    assign fog_ch.ready = rcv_ready;

    exp2_planar_fog_factor #(
        .FRAC_TABLE_BITS(PFF_FRAC_TABLE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .fog    (fog_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    pff_fog_checker #(
        .FRAC_BITS(PFF_FRAC_TABLE_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point_ch),
        .fog        (fog_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle roll for one side: heavy when its own mode is on, light when both idle
    function automatic bit idle_roll(input pace_e own_mode);
        int pct;
        pct = (pace == own_mode) ? 72 : (pace == PACE_BOTH) ? 10 : 0;
        return $urandom_range(99) < pct;
    endfunction

    always @(negedge clk)
        rcv_ready <= !idle_roll(PACE_SINK_STALL);

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((point_ch.valid && point_ch.ready) || (fog_ch.valid && fog_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly a random offset from the camera at a random scale, sometimes anywhere
    function automatic logic [POS_W-1:0] aim(input logic signed [POS_W-1:0] base);
        int off;
        if ($urandom_range(4) == 0)
            return POS_W'($urandom);
        off = int'($urandom) >>> $urandom_range(31, 8);
        return POS_W'(int'(base) + off);
    endfunction

    // Setup and access phase, then the bus returns to idle; enters and leaves at a falling edge
    task automatic write_reg(input pff_reg_e idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setup();
        write_reg(REG_CAMERA_X, 32'(cam_x));
        write_reg(REG_CAMERA_Y, 32'(cam_y));
        write_reg(REG_CAMERA_Z, 32'(cam_z));
        write_reg(REG_FORWARD_X, 32'(fwd_x));
        write_reg(REG_FORWARD_Y, 32'(fwd_y));
        write_reg(REG_FORWARD_Z, 32'(fwd_z));
        write_reg(REG_FOG_DENSITY, 32'(density));
        write_reg(REG_SPARE, $urandom);
    endtask

    task automatic send_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [POS_W-1:0] z);
        while (idle_roll(PACE_SOURCE_IDLE))
        begin
            point_ch.valid <= 1'b0;
            @(negedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= x;
        point_ch.point_y <= y;
        point_ch.point_z <= z;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait for every pending fog mix
    task automatic drain();
        point_ch.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    initial
    begin
        int ph;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        point_ch.valid   = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        cam_x            = CAMERA_RESET;
        cam_y            = CAMERA_RESET;
        cam_z            = CAMERA_RESET;
        fwd_x            = DIR_ONE;
        fwd_y            = FORWARD_YZ_RESET;
        fwd_z            = FORWARD_YZ_RESET;
        density          = DENSITY_RESET;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: origin, field extremes, both signs of depth
        send_point(24'sd0, 24'sd0, 24'sd0);
        send_point(POS_MAX, POS_MAX, POS_MAX);
        send_point(POS_MIN, POS_MIN, POS_MIN);
        send_point(24'sd25600, POS_MIN, POS_MAX);
        send_point(-24'sd256000, -24'sd1, 24'sd1);
        send_point(24'sd256000, 24'sd0, 24'sd0);
        drain();

        // Around the deep fog threshold
        density = 24'd65536;
        apply_setup();
        for (int i = 0; i < 10; i++)
            send_point(POS_W'(BOUNDARY_X[i]), POS_W'($urandom), POS_W'($urandom));
        drain();

        // Random points under a series of settings and pacing modes
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    cam_x   = POS_MAX;
                    cam_y   = POS_MAX;
                    cam_z   = POS_MAX;
                    fwd_x   = -DIR_ONE;
                    fwd_y   = -DIR_ONE;
                    fwd_z   = -DIR_ONE;
                    density = '1;
                end
                1:
                begin
                    cam_x   = POS_MIN;
                    cam_y   = POS_MIN;
                    cam_z   = POS_MIN;
                    fwd_x   = DIR_ONE;
                    fwd_y   = DIR_ONE;
                    fwd_z   = DIR_ONE;
                    density = '0;
                end
                default:
                begin
                    cam_x = POS_W'($urandom);
                    cam_y = POS_W'($urandom);
                    cam_z = POS_W'($urandom);
                    if (ph == 2)
                    begin
                        // forward outside the unit range is used as given
                        fwd_x = 16'sh8000;
                        fwd_y = 16'sh7FFF;
                        fwd_z = DIR_W'($urandom);
                    end
                    else
                    begin
                        fwd_x = DIR_W'(int'($urandom_range(32768)) - 16384);
                        fwd_y = DIR_W'(int'($urandom_range(32768)) - 16384);
                        fwd_z = DIR_W'(int'($urandom_range(32768)) - 16384);
                    end
                    density = DENS_W'($urandom) >> $urandom_range(16);
                end
            endcase
            apply_setup();
            pace = pace_e'(ph % 4);
            repeat (PHASE_ITEMS)
                send_point(aim(cam_x), aim(cam_y), aim(cam_z));
            drain();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/pff_pkg.sv
rtl/pff_stream_if.sv
rtl/exp2_planar_fog_factor.sv
dv/pff_tb_pkg.sv
dv/pff_fog_checker.sv
dv/tb_exp2_planar_fog_factor.sv
